### rtl/core/psts_pkg.sv
package psts_pkg;

   // Field widths fixed by the port list.
   localparam int KIND_W    = 3;
   localparam int IDX_W     = 6;
   localparam int PID_W     = 32;
   localparam int STATE_W   = 3;
   localparam int STATUS_W  = 2;
   localparam int RINDEX_W  = 4;
   localparam int RID_W     = 32;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_CREATE       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXIT         = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP_ID    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LOOKUP_INDEX = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEXT_RUN     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SET_STATE    = 3'd5;

   // Slot state codes.
   localparam logic [STATE_W-1:0] PS_UNUSED     = 3'd0;
   localparam logic [STATE_W-1:0] PS_RUNNABLE   = 3'd1;
   localparam logic [STATE_W-1:0] PS_RECV_WAIT  = 3'd2;
   localparam logic [STATE_W-1:0] PS_SEND_WAIT  = 3'd3;
   localparam logic [STATE_W-1:0] PS_TERMINATED = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DONE,
      SEQ_FETCH,
      SEQ_RESP
   } seq_state_type;

   // Classification of one slot as seen by the compare unit.
   typedef struct packed {
      logic free;
      logic id_hit;
      logic runnable;
      logic running;
      logic terminated;
   } psts_flags_type;

endpackage

### rtl/core/psts_match_unit.sv
// Shared compare unit: classifies the slot currently read from the table.
module psts_match_unit
   import psts_pkg::*;
#(
   parameter int ID_BITS = 32
) (
   input  logic [STATE_W-1:0] slot_state,
   input  logic [ID_BITS-1:0] slot_id,
   input  logic [ID_BITS-1:0] key_id,
   output psts_flags_type     flags
);

   always_comb begin
      flags.free       = (slot_state == PS_UNUSED);
      flags.id_hit     = (slot_id == key_id);
      flags.runnable   = (slot_state == PS_RUNNABLE);
      flags.running    = (slot_state == PS_RUNNABLE) || (slot_state == PS_RECV_WAIT) ||
                         (slot_state == PS_SEND_WAIT);
      flags.terminated = (slot_state == PS_TERMINATED);
   end

endmodule

### rtl/core/process_slot_table_scheduler_core.sv
// Process slot table with a round robin scheduler. Each slot holds a state code and an
// id; one operation is taken per input transfer and exactly one result transfer follows.
// The table lives in two small memories (state and id) with one read and one write port,
// and a sequencer walks them one slot per cycle through a single shared compare unit.
// Create, lookup by id with a nonzero key and next runnable walk every slot; next
// runnable then reads the chosen slot's id once more. Lookup by index reads one slot;
// exit, set state and rejected requests read none. The walk goes at the pace of the one
// read port of the slot memories. The block takes no new request while an operation is
// in progress, but a finished result waits in an output register, so a stalled result
// side does not hold up the next request until that request's own result is ready.
// After reset every slot reads as unused with id zero through per-slot valid bits, so no
// clearing pass is needed, and the id counter starts at one and skips zero on wrap.
module process_slot_table_scheduler_core
   import psts_pkg::*;
#(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [PID_W-1:0]    req_proc_id,
   input  logic [STATE_W-1:0]  req_new_state,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [RINDEX_W-1:0] rsp_result_index,
   output logic [RID_W-1:0]    rsp_result_id
);

   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(SLOTS + 1);

   // Slot memories and their per-entry valid bits.
   logic [STATE_W-1:0] state_mem [SLOTS];
   logic [ID_BITS-1:0] id_mem    [SLOTS];
   logic [SLOTS-1:0]   st_vld_ff;
   logic [SLOTS-1:0]   id_vld_ff;

   logic                 mem_st_we;
   logic                 mem_id_we;
   logic [SLOT_BITS-1:0] mem_waddr;
   logic [STATE_W-1:0]   mem_st_wdata;
   logic [ID_BITS-1:0]   mem_id_wdata;
   logic [SLOT_BITS-1:0] rd_addr;

   // Read pipeline.
   logic [STATE_W-1:0]   rd_state_ff;
   logic [ID_BITS-1:0]   rd_id_ff;
   logic                 rd_sv_ff;
   logic                 rd_iv_ff;
   logic                 rd_vld_ff,  rd_vld_in;
   logic                 rd_last_ff, rd_last_in;
   logic [SLOT_BITS-1:0] rd_slot_ff, rd_slot_in;

   // Sequencer.
   seq_state_type        seq_ff, seq_in;
   logic [KIND_W-1:0]    op_ff, op_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [ID_BITS-1:0]   key_ff, key_in;
   logic [SLOT_BITS-1:0] ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]  issue_cnt_ff, issue_cnt_in;
   logic                 single_ff, single_in;
   logic                 found_ff, found_in;
   logic                 term1_ff, term1_in;
   logic [SLOT_BITS-1:0] hit_slot_ff, hit_slot_in;
   logic [ID_BITS-1:0]   hit_id_ff, hit_id_in;
   logic [ID_BITS-1:0]   next_id_ff, next_id_in;

   // Pending result and output register.
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [RINDEX_W-1:0]  res_index_ff, res_index_in;
   logic [RID_W-1:0]     res_id_ff, res_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [RINDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [RID_W-1:0]     rsp_id_ff, rsp_id_in;

   // Helper values.
   logic [STATE_W-1:0]       cur_state;
   logic [ID_BITS-1:0]       cur_id;
   psts_flags_type           flags;
   logic [ID_BITS+PID_W-1:0] key_ext;
   logic [ID_BITS-1:0]       req_key;
   logic                     in_range;
   logic [SLOT_BITS-1:0]     req_idx;
   logic [SLOT_BITS-1:0]     ptr_step;
   logic [SLOT_BITS-1:0]     rr_start;
   logic                     issue_done;
   logic                     issue_last;
   logic [ID_BITS-1:0]       nid_inc;
   logic [SLOT_BITS-1:0]     pick;
   logic [SLOT_BITS+RINDEX_W-1:0] idx_ext;
   logic [SLOT_BITS+RINDEX_W-1:0] hslot_ext;
   logic [ID_BITS+RID_W-1:0]  nid_ext;
   logic [ID_BITS+RID_W-1:0]  hid_ext;
   logic [ID_BITS+RID_W-1:0]  cid_ext;

   // A slot whose entry was never written reads as unused with id zero.
   assign cur_state = rd_sv_ff ? rd_state_ff : PS_UNUSED;
   assign cur_id    = rd_iv_ff ? rd_id_ff : '0;

   psts_match_unit #(
      .ID_BITS (ID_BITS)
   ) u_match (
      .slot_state (cur_state),
      .slot_id    (cur_id),
      .key_id     (key_ff),
      .flags      (flags)
   );

   // The id key is the request id masked to ID_BITS.
   assign key_ext  = {{ID_BITS{1'b0}}, req_proc_id};
   assign req_key  = key_ext[ID_BITS-1:0];
   assign in_range = ({1'b0, req_slot_index} < (IDX_W + 1)'(SLOTS));
   assign req_idx  = req_slot_index[SLOT_BITS-1:0];
   assign rr_start = (req_idx == SLOT_BITS'(SLOTS - 1)) ? '0 : req_idx + 1'b1;
   assign ptr_step = (ptr_ff == SLOT_BITS'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;

   assign issue_done = single_ff ? (issue_cnt_ff != '0) : (issue_cnt_ff == CNT_BITS'(SLOTS));
   assign issue_last = single_ff || (issue_cnt_ff == CNT_BITS'(SLOTS - 1));

   assign nid_inc = next_id_ff + 1'b1;

   // If slot 1 has terminated the answer is always the idle slot.
   assign pick = (term1_ff || !found_ff) ? '0 : hit_slot_ff;

   // Results give the low bits of slot numbers and ids.
   assign idx_ext   = {{RINDEX_W{1'b0}}, idx_ff};
   assign hslot_ext = {{RINDEX_W{1'b0}}, hit_slot_ff};
   assign nid_ext   = {{RID_W{1'b0}}, next_id_ff};
   assign hid_ext   = {{RID_W{1'b0}}, hit_id_ff};
   assign cid_ext   = {{RID_W{1'b0}}, cur_id};

   assign req_stall        = (seq_ff != SEQ_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_id    = rsp_id_ff;

   always_comb begin
      seq_in        = seq_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      issue_cnt_in  = issue_cnt_ff;
      single_in     = single_ff;
      found_in      = found_ff;
      term1_in      = term1_ff;
      hit_slot_in   = hit_slot_ff;
      hit_id_in     = hit_id_ff;
      next_id_in    = next_id_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_id_in     = res_id_ff;
      rd_vld_in     = 1'b0;
      rd_last_in    = 1'b0;
      rd_slot_in    = rd_slot_ff;
      rd_addr       = ptr_ff;
      mem_st_we     = 1'b0;
      mem_id_we     = 1'b0;
      mem_waddr     = req_idx;
      mem_st_wdata  = PS_UNUSED;
      mem_id_wdata  = '0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_id_in     = rsp_id_ff;

      case (seq_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               op_in         = req_kind;
               idx_in        = req_idx;
               key_in        = req_key;
               issue_cnt_in  = '0;
               single_in     = 1'b0;
               found_in      = 1'b0;
               term1_in      = 1'b0;
               hit_slot_in   = '0;
               hit_id_in     = '0;
               res_status_in = STAT_MISS;
               res_index_in  = '0;
               res_id_in     = '0;
               seq_in        = SEQ_RESP;
               case (req_kind)
                  KIND_CREATE: begin
                     ptr_in = '0;
                     seq_in = SEQ_SCAN;
                  end
                  KIND_EXIT: begin
                     if (!in_range) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        mem_st_we     = 1'b1;
                        mem_id_we     = 1'b1;
                        res_status_in = STAT_OK;
                        res_index_in  = req_slot_index[RINDEX_W-1:0];
                     end
                  end
                  KIND_LOOKUP_ID: begin
                     if (req_key != '0) begin
                        ptr_in = '0;
                        seq_in = SEQ_SCAN;
                     end
                  end
                  KIND_LOOKUP_INDEX: begin
                     if (!in_range) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        ptr_in    = req_idx;
                        single_in = 1'b1;
                        seq_in    = SEQ_SCAN;
                     end
                  end
                  KIND_NEXT_RUN: begin
                     if (!in_range) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        ptr_in = rr_start;
                        seq_in = SEQ_SCAN;
                     end
                  end
                  KIND_SET_STATE: begin
                     if (!in_range) begin
                        res_status_in = STAT_RANGE;
                     end else if (req_new_state <= PS_TERMINATED) begin
                        mem_st_we     = 1'b1;
                        mem_st_wdata  = req_new_state;
                        res_status_in = STAT_OK;
                        res_index_in  = req_slot_index[RINDEX_W-1:0];
                     end
                  end
                  default: begin
                     res_status_in = STAT_MISS;
                  end
               endcase
            end
         end

         SEQ_SCAN: begin
            if (!issue_done) begin
               rd_vld_in    = 1'b1;
               rd_last_in   = issue_last;
               rd_slot_in   = ptr_ff;
               ptr_in       = ptr_step;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               case (op_ff)
                  KIND_CREATE: begin
                     if (flags.free && !found_ff) begin
                        found_in    = 1'b1;
                        hit_slot_in = rd_slot_ff;
                     end
                  end
                  KIND_LOOKUP_ID: begin
                     if (flags.id_hit && !flags.free && !found_ff) begin
                        found_in    = 1'b1;
                        hit_slot_in = rd_slot_ff;
                        hit_id_in   = cur_id;
                     end
                  end
                  KIND_LOOKUP_INDEX: begin
                     if (flags.running) begin
                        found_in  = 1'b1;
                        hit_id_in = cur_id;
                     end
                  end
                  KIND_NEXT_RUN: begin
                     if (flags.runnable && (rd_slot_ff != '0) && !found_ff) begin
                        found_in    = 1'b1;
                        hit_slot_in = rd_slot_ff;
                     end
                     if ((rd_slot_ff == SLOT_BITS'(1)) && flags.terminated) begin
                        term1_in = 1'b1;
                     end
                  end
                  default: begin
                     found_in = found_ff;
                  end
               endcase
               if (rd_last_ff) begin
                  seq_in = SEQ_DONE;
               end
            end
         end

         SEQ_DONE: begin
            seq_in = SEQ_RESP;
            case (op_ff)
               KIND_CREATE: begin
                  if (found_ff) begin
                     mem_st_we     = 1'b1;
                     mem_id_we     = 1'b1;
                     mem_waddr     = hit_slot_ff;
                     mem_st_wdata  = PS_RUNNABLE;
                     mem_id_wdata  = next_id_ff;
                     next_id_in    = (nid_inc == '0) ? ID_BITS'(1) : nid_inc;
                     res_status_in = STAT_OK;
                     res_index_in  = hslot_ext[RINDEX_W-1:0];
                     res_id_in     = nid_ext[RID_W-1:0];
                  end
               end
               KIND_LOOKUP_ID: begin
                  if (found_ff) begin
                     res_status_in = STAT_OK;
                     res_index_in  = hslot_ext[RINDEX_W-1:0];
                     res_id_in     = hid_ext[RID_W-1:0];
                  end
               end
               KIND_LOOKUP_INDEX: begin
                  if (found_ff) begin
                     res_status_in = STAT_OK;
                     res_index_in  = idx_ext[RINDEX_W-1:0];
                     res_id_in     = hid_ext[RID_W-1:0];
                  end
               end
               KIND_NEXT_RUN: begin
                  rd_addr     = pick;
                  hit_slot_in = pick;
                  seq_in      = SEQ_FETCH;
               end
               default: begin
                  seq_in = SEQ_RESP;
               end
            endcase
         end

         SEQ_FETCH: begin
            res_status_in = STAT_OK;
            res_index_in  = hslot_ext[RINDEX_W-1:0];
            res_id_in     = cid_ext[RID_W-1:0];
            seq_in        = SEQ_RESP;
         end

         SEQ_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_id_in     = res_id_ff;
               seq_in        = SEQ_IDLE;
            end
         end

         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // Slot memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_st_we) begin
         state_mem[mem_waddr] <= mem_st_wdata;
      end
      if (mem_id_we) begin
         id_mem[mem_waddr] <= mem_id_wdata;
      end
      rd_state_ff <= state_mem[rd_addr];
      rd_id_ff    <= id_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         st_vld_ff    <= '0;
         id_vld_ff    <= '0;
         rd_sv_ff     <= 1'b0;
         rd_iv_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         next_id_ff   <= ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         rd_sv_ff     <= st_vld_ff[rd_addr];
         rd_iv_ff     <= id_vld_ff[rd_addr];
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_st_we) begin
            st_vld_ff[mem_waddr] <= 1'b1;
         end
         if (mem_id_we) begin
            id_vld_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      issue_cnt_ff  <= issue_cnt_in;
      single_ff     <= single_in;
      found_ff      <= found_in;
      term1_ff      <= term1_in;
      hit_slot_ff   <= hit_slot_in;
      hit_id_ff     <= hit_id_in;
      rd_slot_ff    <= rd_slot_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_id_ff     <= rsp_id_in;
   end

endmodule
